>>> src/sfcd_pkg.sv
package sfcd_pkg;

  // Largest payload the deframer will accept, whatever the limit register says
  localparam int unsigned PAYLOAD_CAPACITY = 256;
  // Width that holds any accepted length or byte count
  localparam int unsigned LEN_W = $clog2(PAYLOAD_CAPACITY + 1);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned MAX_LEN_W = 9;
  localparam int unsigned FRAME_LEN_W = 9;

  localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = MAX_LEN_W'(256);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LEN     = 2'd2
  } cfg_idx_t;

  // Result kinds
  typedef enum logic {
    KIND_PAYLOAD  = 1'b0,
    KIND_COMPLETE = 1'b1
  } kind_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN_L   = 3'd3,
    PH_LEN_H   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC_L   = 3'd6,
    PH_CRC_H   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0]           sync_first;
    logic [7:0]           sync_second;
    logic [MAX_LEN_W-1:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             data_byte;
    logic [7:0]             byte_index;
    logic [7:0]             command_code;
    logic [FRAME_LEN_W-1:0] frame_length;
  } result_t;

endpackage

>>> src/sfcd_parser.sv
module sfcd_parser (
  input  logic            clk,
  input  logic            rst,
  input  sfcd_pkg::cfg_t  cfg,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output logic            res_valid,
  output sfcd_pkg::result_t res
);
  import sfcd_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic [7:0]         len_lo;
  logic [LEN_W-1:0]   exp_len;
  logic [LEN_W-1:0]   seen;
  logic [7:0]         opcode;

  logic [15:0]        full_len;
  logic [15:0]        limit;
  logic               too_long;
  logic [LEN_W-1:0]   seen_inc;
  logic               payload_done;

  // Length check against the smaller of the register and the capacity
  assign full_len = {rx_byte, len_lo};
  assign limit = (16'(cfg.max_payload_len) > 16'(PAYLOAD_CAPACITY)) ?
                 16'(PAYLOAD_CAPACITY) : 16'(cfg.max_payload_len);
  assign too_long = full_len > limit;
  assign seen_inc = seen + LEN_W'(1);
  assign payload_done = seen_inc >= exp_len;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC0:   if (rx_byte == cfg.sync_first) phase_next = PH_SYNC1;
      PH_SYNC1:   phase_next = (rx_byte == cfg.sync_second) ? PH_CMD : PH_SYNC0;
      PH_CMD:     phase_next = PH_LEN_L;
      PH_LEN_L:   phase_next = PH_LEN_H;
      PH_LEN_H: begin
        if (too_long) phase_next = PH_SYNC0;
        else if (full_len == 16'd0) phase_next = PH_CRC_L;
        else phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: if (payload_done) phase_next = PH_CRC_L;
      PH_CRC_L:   phase_next = PH_CRC_H;
      PH_CRC_H:   phase_next = PH_SYNC0;
      default:    phase_next = PH_SYNC0;
    endcase
  end

  // Result for the byte now on the input
  always_comb begin
    res_valid = 1'b0;
    res.kind = KIND_PAYLOAD;
    res.data_byte = 8'd0;
    res.byte_index = 8'd0;
    res.command_code = opcode;
    res.frame_length = FRAME_LEN_W'(exp_len);
    unique case (phase)
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.data_byte = rx_byte;
        res.byte_index = 8'(seen);
      end
      PH_CRC_H: begin
        res_valid = 1'b1;
        res.kind = KIND_COMPLETE;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // Advance phase on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC0;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Capture header fields and count payload bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      len_lo <= 8'd0;
      exp_len <= '0;
      seen <= '0;
      opcode <= 8'd0;
    end else if (step) begin
      case (phase)
        PH_CMD:     opcode <= rx_byte;
        PH_LEN_L:   len_lo <= rx_byte;
        PH_LEN_H: begin
          exp_len <= full_len[LEN_W-1:0];
          seen <= '0;
        end
        PH_PAYLOAD: seen <= seen_inc;
        default:    seen <= seen;
      endcase
    end
  end

endmodule

>>> src/sfcd_out_reg.sv
module sfcd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              res_valid,
  input  sfcd_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output sfcd_pkg::result_t out_res,
  output logic              full_stalled
);
  import sfcd_pkg::*;

  // Block new input only while a held result is stalled
  assign full_stalled = out_valid && out_stall;

  // Hold until taken; load replaces a result that leaves this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> src/sync_framed_command_deframer.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    rx_byte
// out      output     out_valid / out_stall  kind, data_byte, byte_index,
//                                            command_code, frame_length
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte a cycle while in_stall is low: the parser decides on the byte during the
// cycle of its transfer and any result appears in the output register in the next cycle.
// in_stall rises only while a held result is stalled by out_stall.
// Synchronous reset returns the parser to sync hunting and loads the
// register defaults; cfg_ready is always high.
module sync_framed_command_deframer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic [7:0]                       data_byte,
  output logic [7:0]                       byte_index,
  output logic [7:0]                       command_code,
  output logic [sfcd_pkg::FRAME_LEN_W-1:0] frame_length,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfcd_pkg::*;

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign step = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.max_payload_len <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  cfg.sync_first <= cfg_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second <= cfg_data[7:0];
        CFG_MAX_LEN:     cfg.max_payload_len <= cfg_data[MAX_LEN_W-1:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  sfcd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfcd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .res_valid    (res_valid),
    .res          (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .full_stalled (in_stall)
  );

  assign kind = out_res.kind;
  assign data_byte = out_res.data_byte;
  assign byte_index = out_res.byte_index;
  assign command_code = out_res.command_code;
  assign frame_length = out_res.frame_length;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_complete_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_COMPLETE) |-> (data_byte == 8'd0 && byte_index == 8'd0))
    else $error("frame-complete result carries payload fields");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PAYLOAD) |-> (FRAME_LEN_W'(byte_index) < frame_length))
    else $error("payload index beyond frame length");

  a_result_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !$past(step)) |=> !out_valid || $past(step))
    else $error("result appeared without an input transfer");
`endif

endmodule
